@@ hdl/sdpms_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpms_pkg
// Types, codes and constants of the servo drive power and move sequencer.
// ----------------------------------------------------------------------------
package sdpms_pkg;

	localparam int POSITION_WIDTH = 32;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_SON  = 2'd1,
		FUNC_SOFF = 2'd2,
		FUNC_MOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_CLEAR_WAIT   = 2'd0,
		CFG_SETPOINT_LOW = 2'd1,
		CFG_ACK_WAIT     = 2'd2,
		CFG_REACH_TIME   = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SON   = 3'd1,
		PH_SOFF  = 3'd2,
		PH_CLEAR = 3'd3,
		PH_SPLOW = 3'd4,
		PH_ACK   = 3'd5,
		PH_REACH = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		DS_SWITCH_DISABLED = 3'd0,
		DS_READY           = 3'd1,
		DS_SWITCHED_ON     = 3'd2,
		DS_OP_ENABLED      = 3'd3,
		DS_FAULT           = 3'd4,
		DS_UNKNOWN         = 3'd5
	} drive_state_t;

	localparam logic [15:0] SW_MASK_SHORT = 16'h004F;
	localparam logic [15:0] SW_MASK_LONG  = 16'h006F;
	localparam logic [15:0] SW_SWITCH_DIS = 16'h0040;
	localparam logic [15:0] SW_READY      = 16'h0021;
	localparam logic [15:0] SW_SWITCHED   = 16'h0023;
	localparam logic [15:0] SW_OP_EN      = 16'h0027;
	localparam logic [15:0] SW_FAULT      = 16'h0008;

	localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
	localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
	localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
	localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
	localparam logic [15:0] CW_DISABLE     = 16'h0000;

	localparam logic [15:0] BIT_SETPOINT = 16'h0010;
	localparam logic [15:0] BIT_ABS      = 16'h0040;
	localparam logic [15:0] BIT_REACHED  = 16'h0400;
	localparam logic [15:0] BIT_ACK      = 16'h1000;

	localparam logic [7:0]  MODE_PROFILE_POS = 8'd1;
	localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

	typedef struct packed {
		logic [15:0] clear_wait_ticks;
		logic [15:0] setpoint_low_ticks;
		logic [15:0] ack_wait_ticks;
		logic [15:0] reach_timeout_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic [15:0]        control_word;
		logic signed [31:0] target_command;
		logic [7:0]         operating_mode;
		logic [2:0]         drive_state;
		logic               busy_res;
		logic               done_res;
		logic               success;
	} result_t;

	function automatic drive_state_t decode_state(input logic [15:0] sw);
		drive_state_t st;
		if ((sw & SW_MASK_SHORT) == SW_SWITCH_DIS)     st = DS_SWITCH_DISABLED;
		else if ((sw & SW_MASK_LONG) == SW_READY)      st = DS_READY;
		else if ((sw & SW_MASK_LONG) == SW_SWITCHED)   st = DS_SWITCHED_ON;
		else if ((sw & SW_MASK_LONG) == SW_OP_EN)      st = DS_OP_ENABLED;
		else if ((sw & SW_MASK_SHORT) == SW_FAULT)     st = DS_FAULT;
		else                                           st = DS_UNKNOWN;
		return st;
	endfunction

	function automatic logic signed [31:0] fit_position(input logic signed [31:0] v);
		logic signed [POSITION_WIDTH-1:0] t;
		t = v[POSITION_WIDTH-1:0];
		return 32'(t);
	endfunction

endpackage

@@ hdl/sdpms_cmd_if.sv @@
// ----------------------------------------------------------------------------
// sdpms_cmd_if
// Input channel: one beat per tick with request code, status word and target.
// ----------------------------------------------------------------------------
interface sdpms_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [15:0]        status_word;
	logic signed [31:0] target_position;

	modport source (output valid, output func, output status_word,
		output target_position, input ready);
	modport sink (input valid, input func, input status_word,
		input target_position, output ready);
endinterface

@@ hdl/sdpms_res_if.sv @@
// ----------------------------------------------------------------------------
// sdpms_res_if
// Result channel: one beat per tick with control word, target, mode and status.
// ----------------------------------------------------------------------------
interface sdpms_res_if;
	logic               valid;
	logic               ready;
	logic [15:0]        control_word;
	logic signed [31:0] target_command;
	logic [7:0]         operating_mode;
	logic [2:0]         drive_state;
	logic               busy_res;
	logic               done_res;
	logic               success;

	modport source (output valid, output control_word, output target_command,
		output operating_mode, output drive_state, output busy_res,
		output done_res, output success, input ready);
	modport sink (input valid, input control_word, input target_command,
		input operating_mode, input drive_state, input busy_res,
		input done_res, input success, output ready);
endinterface

@@ hdl/sdpms_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sdpms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdpms_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/sdpms_core.sv @@
// ----------------------------------------------------------------------------
// sdpms_core
// Sequencer state and one-tick step logic: power state decode, servo on/off
// stepping and the profile position move handshake.
// ----------------------------------------------------------------------------
module sdpms_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          func,
	input  logic [15:0]         status_word,
	input  logic signed [31:0]  target_position,
	input  sdpms_pkg::cfg_regs_t cfg,
	output sdpms_pkg::result_t  result
);
	import sdpms_pkg::*;

	phase_t             phase_q, phase_d;
	logic [15:0]        wait_q, wait_d;
	logic [15:0]        ctrl_q, ctrl_d;
	logic signed [31:0] target_q, target_d;
	logic [7:0]         mode_q, mode_d;
	logic signed [31:0] pend_q, pend_d;
	drive_state_t       st;
	logic               done, ok;

	always_comb begin
		st       = decode_state(status_word);
		phase_d  = phase_q;
		wait_d   = wait_q;
		ctrl_d   = ctrl_q;
		target_d = target_q;
		mode_d   = mode_q;
		pend_d   = pend_q;
		done     = 1'b0;
		ok       = 1'b0;

		if (phase_q == PH_IDLE && func_t'(func) != FUNC_TICK) begin
			wait_d = '0;
			case (func_t'(func))
				FUNC_SON: begin
					mode_d  = MODE_PROFILE_POS;
					phase_d = PH_SON;
				end
				FUNC_SOFF: phase_d = PH_SOFF;
				default: begin
					pend_d  = fit_position(target_position);
					phase_d = PH_CLEAR;
				end
			endcase
		end

		case (phase_d)
			PH_SON: begin
				if (st == DS_OP_ENABLED) begin
					done = 1'b1; ok = 1'b1; phase_d = PH_IDLE;
				end else begin
					case (st)
						DS_READY:       ctrl_d = CW_SWITCH_ON;
						DS_SWITCHED_ON: ctrl_d = CW_ENABLE_OP;
						DS_FAULT:       ctrl_d = CW_FAULT_RESET;
						default:        ctrl_d = CW_SHUTDOWN;
					endcase
				end
			end
			PH_SOFF: begin
				if (st == DS_SWITCH_DISABLED) begin
					done = 1'b1; ok = 1'b1; phase_d = PH_IDLE;
				end else begin
					case (st)
						DS_OP_ENABLED:  ctrl_d = CW_SWITCH_ON;
						DS_SWITCHED_ON: ctrl_d = CW_SHUTDOWN;
						DS_FAULT:       ctrl_d = CW_FAULT_RESET;
						default:        ctrl_d = CW_DISABLE;
					endcase
				end
			end
			PH_CLEAR: begin
				if (wait_d >= cfg.clear_wait_ticks || (status_word & BIT_REACHED) == '0) begin
					target_d = pend_d;
					ctrl_d   = (ctrl_d | CW_ENABLE_OP) & ~(BIT_ABS | BIT_SETPOINT);
					wait_d   = '0;
					phase_d  = PH_SPLOW;
				end else if (wait_d != COUNT_MAX) begin
					wait_d = wait_d + 16'd1;
				end
			end
			PH_SPLOW: begin
				if (wait_d != COUNT_MAX) wait_d = wait_d + 16'd1;
				if (wait_d >= cfg.setpoint_low_ticks) begin
					ctrl_d  = ctrl_d | BIT_SETPOINT;
					wait_d  = '0;
					phase_d = PH_ACK;
				end
			end
			PH_ACK: begin
				if (wait_d >= cfg.ack_wait_ticks || (status_word & BIT_ACK) != '0) begin
					wait_d  = '0;
					phase_d = PH_REACH;
				end else if (wait_d != COUNT_MAX) begin
					wait_d = wait_d + 16'd1;
				end
			end
			PH_REACH: begin
				if (wait_d >= cfg.reach_timeout_ticks) begin
					done = 1'b1;
				end else if ((status_word & BIT_REACHED) != '0) begin
					done = 1'b1; ok = 1'b1;
				end else if (wait_d != COUNT_MAX) begin
					wait_d = wait_d + 16'd1;
				end
				if (done) begin
					ctrl_d  = ctrl_d & ~BIT_SETPOINT;
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		result.control_word   = ctrl_d;
		result.target_command = target_d;
		result.operating_mode = mode_d;
		result.drive_state    = st;
		result.busy_res       = (phase_d != PH_IDLE);
		result.done_res       = done;
		result.success        = done && ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			ctrl_q   <= '0;
			target_q <= '0;
			mode_q   <= '0;
			pend_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			ctrl_q   <= ctrl_d;
			target_q <= target_d;
			mode_q   <= mode_d;
			pend_q   <= pend_d;
		end
	end

endmodule

@@ hdl/servo_drive_power_and_move_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// servo_drive_power_and_move_sequencer_top
// CiA 402 master-side power and profile position move sequencer.
// ----------------------------------------------------------------------------
// One command beat per drive tick goes in and exactly one result beat comes
// out through the input register and the result register when the result
// side is ready. A beat is taken every cycle while the result side is ready:
// the input register feeds the step logic, which updates the sequencer state
// and loads the result register in the same cycle, so the rate is one beat
// per clock. Timeouts count ticks (beats), not clocks. The configuration port
// always accepts writes; write it only while no sequence is in progress.
module servo_drive_power_and_move_sequencer_top (
	input logic         clk,
	input logic         arst_n,
	sdpms_cmd_if.sink   cmd,
	sdpms_res_if.source res,
	sdpms_cfg_if.sink   cfg
);
	import sdpms_pkg::*;

	cfg_regs_t          cfg_q;
	logic               v_s1, v_s2;
	logic [1:0]         func_s1;
	logic [15:0]        sw_s1;
	logic signed [31:0] tp_s1;
	result_t            res_s2;
	result_t            step_res;
	logic               adv;

	assign adv       = v_s1 && (!v_s2 || res.ready);
	assign cmd.ready = !v_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clear_wait_ticks    <= 16'd1000;
			cfg_q.setpoint_low_ticks  <= 16'd2;
			cfg_q.ack_wait_ticks      <= 16'd2000;
			cfg_q.reach_timeout_ticks <= 16'd5000;
		end else if (cfg.valid) begin
			case (cfg_index_t'(cfg.index))
				CFG_CLEAR_WAIT:   cfg_q.clear_wait_ticks    <= cfg.data;
				CFG_SETPOINT_LOW: cfg_q.setpoint_low_ticks  <= cfg.data;
				CFG_ACK_WAIT:     cfg_q.ack_wait_ticks      <= cfg.data;
				default:          cfg_q.reach_timeout_ticks <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (cmd.ready) v_s1 <= cmd.valid;
			if (adv) v_s2 <= 1'b1;
			else if (res.ready) v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1 <= cmd.func;
			sw_s1   <= cmd.status_word;
			tp_s1   <= cmd.target_position;
		end
		if (adv) res_s2 <= step_res;
	end

	sdpms_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (adv),
		.func            (func_s1),
		.status_word     (sw_s1),
		.target_position (tp_s1),
		.cfg             (cfg_q),
		.result          (step_res)
	);

	assign res.valid          = v_s2;
	assign res.control_word   = res_s2.control_word;
	assign res.target_command = res_s2.target_command;
	assign res.operating_mode = res_s2.operating_mode;
	assign res.drive_state    = res_s2.drive_state;
	assign res.busy_res       = res_s2.busy_res;
	assign res.done_res       = res_s2.done_res;
	assign res.success        = res_s2.success;

endmodule
